@@ rtl/plap_pkg.sv @@
// Shared types and constants for the positional list block.
package plap_pkg;

  // Command codes carried in the request
  localparam logic [1:0] CmdInsert    = 2'd0;
  localparam logic [1:0] CmdDeleteAt  = 2'd1;
  localparam logic [1:0] CmdDeleteVal = 2'd2;

  // Fixed field widths of the request and result
  localparam int unsigned CmdW     = 2;
  localparam int unsigned ValW     = 32;
  localparam int unsigned PosW     = 5;
  localparam int unsigned CntOutW  = 5;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // latch request, set up pointers
    logic run;     // shift / compact phase
    logic commit;  // final write, count update, load result
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;  // no read issued and none in flight
    logic out_free;   // result register can take a new result
  } stat_t;

endpackage

@@ rtl/plap_ctrl.sv @@
// Controller state machine for the positional list block.
module plap_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  plap_pkg::stat_t stat_i,
  output plap_pkg::ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StRun    = 3'b010,
    StFinish = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) state_d = StRun;
      end
      StRun: begin
        if (stat_i.scan_done) state_d = StFinish;
      end
      StFinish: begin
        if (stat_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o   = (state_q == StIdle);
  assign ctrl_o.start  = (state_q == StIdle) && req_valid_i;
  assign ctrl_o.run    = (state_q == StRun);
  assign ctrl_o.commit = (state_q == StFinish) && stat_i.out_free;

endmodule

@@ rtl/plap_dpath.sv @@
// Datapath for the positional list block: list memory, pointers, count, result register.
module plap_dpath #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  plap_pkg::ctrl_t                ctrl_i,
  output plap_pkg::stat_t                stat_o,
  input  logic [plap_pkg::CmdW-1:0]      cmd_i,
  input  logic [plap_pkg::ValW-1:0]      value_i,
  input  logic [plap_pkg::PosW-1:0]      position_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           ok_o,
  output logic [plap_pkg::CntOutW-1:0]   count_after_o
);

  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW  = $clog2(CAPACITY);
  localparam int unsigned CmpW   = (CntW > plap_pkg::PosW) ? CntW : plap_pkg::PosW;
  localparam int unsigned StoreW = (VALUE_WIDTH < plap_pkg::ValW) ? VALUE_WIDTH
                                                                  : plap_pkg::ValW;

  logic [StoreW-1:0] mem_q [CAPACITY];

  logic [plap_pkg::CmdW-1:0] cmd_q;
  logic [StoreW-1:0]         val_q;
  logic [CntW-1:0]           pos_q;
  logic                      ok_q;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [CntW-1:0]           rd_q, rd_d;
  logic [CntW-1:0]           wr_q, wr_d;
  logic                      rv_q;
  logic [StoreW-1:0]         rdata_q;
  logic                      out_valid_q;
  logic                      out_ok_q;
  logic [plap_pkg::CntOutW-1:0] out_cnt_q;

  logic [CmpW-1:0]  cnt_ext, pos_ext, cnt_d_ext;
  logic [CntW-1:0]  pos_new, rd_dec;
  logic             ok_new;
  logic             is_insert;
  logic             issue;
  logic [AddrW-1:0] raddr;
  logic             keep;
  logic             out_free;

  assign cnt_ext   = CmpW'(cnt_q);
  assign pos_ext   = CmpW'(position_i);
  assign pos_new   = pos_ext[CntW-1:0];
  assign is_insert = (cmd_q == plap_pkg::CmdInsert);
  assign rd_dec    = rd_q - CntW'(1);

  // Validity of the incoming request against the current count
  always_comb begin
    unique case (cmd_i)
      plap_pkg::CmdInsert:    ok_new = (pos_ext <= cnt_ext) && (cnt_q != CntW'(CAPACITY));
      plap_pkg::CmdDeleteAt:  ok_new = (pos_ext < cnt_ext);
      plap_pkg::CmdDeleteVal: ok_new = 1'b1;
      default:                ok_new = 1'b0;
    endcase
  end

  // Insert walks down from the top, the deletes walk up from their start
  always_comb begin
    issue = 1'b0;
    rd_d  = rd_q;
    raddr = rd_q[AddrW-1:0];
    if (is_insert) begin
      raddr = rd_dec[AddrW-1:0];
      if (ctrl_i.run && ok_q && (rd_q > pos_q)) begin
        issue = 1'b1;
        rd_d  = rd_dec;
      end
    end else begin
      if (ctrl_i.run && ok_q && (rd_q < cnt_q)) begin
        issue = 1'b1;
        rd_d  = rd_q + CntW'(1);
      end
    end
    if (ctrl_i.start) begin
      unique case (cmd_i)
        plap_pkg::CmdInsert:   rd_d = cnt_q;
        plap_pkg::CmdDeleteAt: rd_d = pos_new + CntW'(1);
        default:               rd_d = '0;
      endcase
    end
  end

  // Delete-value drops matching entries; the shifts keep every entry
  assign keep = rv_q && ((cmd_q != plap_pkg::CmdDeleteVal) || (rdata_q != val_q));

  always_comb begin
    wr_d = wr_q;
    if (keep) begin
      wr_d = is_insert ? (wr_q - CntW'(1)) : (wr_q + CntW'(1));
    end
    if (ctrl_i.start) begin
      unique case (cmd_i)
        plap_pkg::CmdInsert:   wr_d = cnt_q;
        plap_pkg::CmdDeleteAt: wr_d = pos_new;
        default:               wr_d = '0;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.commit && ok_q) begin
      unique case (cmd_q)
        plap_pkg::CmdInsert:    cnt_d = cnt_q + CntW'(1);
        plap_pkg::CmdDeleteAt:  cnt_d = cnt_q - CntW'(1);
        plap_pkg::CmdDeleteVal: cnt_d = wr_q;
        default:                cnt_d = cnt_q;
      endcase
    end
  end

  assign cnt_d_ext = CmpW'(cnt_d);
  assign out_free  = !out_valid_q || out_ready_i;

  // List memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && ok_q && is_insert) begin
      mem_q[pos_q[AddrW-1:0]] <= val_q;
    end else if (keep) begin
      mem_q[wr_q[AddrW-1:0]] <= rdata_q;
    end
    if (issue) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      val_q <= value_i[StoreW-1:0];
      pos_q <= pos_new;
    end
    if (ctrl_i.commit) begin
      out_ok_q  <= ok_q;
      out_cnt_q <= cnt_d_ext[plap_pkg::CntOutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= plap_pkg::CmdInsert;
      ok_q        <= 1'b0;
      cnt_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.start) begin
        cmd_q <= cmd_i;
        ok_q  <= ok_new;
      end
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      rv_q  <= issue;
      if (ctrl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.scan_done = !issue && !rv_q;
  assign stat_o.out_free  = out_free;
  assign out_valid_o      = out_valid_q;
  assign ok_o             = out_ok_q;
  assign count_after_o    = out_cnt_q;

endmodule

@@ rtl/positional_list_insert_delete_top.sv @@
// Top level of the positional list block: ordered list with insert and delete.
//
// Requests arrive on the s_axis channel: command, value and position. Command
// insert puts value at position (0..count) and moves later entries up; delete-at
// removes the entry at position (below count) and moves later entries down;
// delete-value removes every entry equal to value and compacts the rest.
// Each request gives exactly one result on m_axis: ok flag and the new count.
// A request that fails leaves the list untouched and returns ok = 0.
//
// Timing: one request at a time. Once a request is taken, entries move one per cycle
// through the list memory (each kept entry is written in the cycle after its read),
// then the scan drains and the result is committed. Insert moves count - position
// entries, delete-at count - position - 1, and delete-value reads all count entries;
// a failed request moves none. The longest request is delete-value on a full list.
// The result sits in an output register, so the list work never waits on the
// receiver; only the commit of the next result waits while m_axis_tready is low
// and the previous result is still held. Reset empties the list (count = 0)
// and clears any pending result; memory contents are not cleared.
module positional_list_insert_delete_top #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // command [1:0], value [33:2], position [38:34], zero [39]
  input  logic [plap_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // ok [0], count_after [5:1], zero [7:6]
  output logic [plap_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int unsigned ValLo = plap_pkg::CmdW;
  localparam int unsigned PosLo = plap_pkg::CmdW + plap_pkg::ValW;
  localparam int unsigned OutPad = plap_pkg::OutDataW - 1 - plap_pkg::CntOutW;

  plap_pkg::ctrl_t ctrl;
  plap_pkg::stat_t stat;

  logic [plap_pkg::CmdW-1:0]    req_cmd;
  logic [plap_pkg::ValW-1:0]    req_value;
  logic [plap_pkg::PosW-1:0]    req_pos;
  logic                         res_ok;
  logic [plap_pkg::CntOutW-1:0] res_cnt;

  assign req_cmd   = s_axis_tdata[plap_pkg::CmdW-1:0];
  assign req_value = s_axis_tdata[ValLo +: plap_pkg::ValW];
  assign req_pos   = s_axis_tdata[PosLo +: plap_pkg::PosW];

  plap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  plap_dpath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cmd_i         (req_cmd),
    .value_i       (req_value),
    .position_i    (req_pos),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .ok_o          (res_ok),
    .count_after_o (res_cnt)
  );

  assign m_axis_tdata = {{OutPad{1'b0}}, res_cnt, res_ok};

endmodule

@@ tb/positional_list_insert_delete_top_test.sv @@
// Self-checking testbench for the positional list block, with a shadow list predictor.
`timescale 1ns / 100ps

typedef struct packed {
  logic       ok;
  logic [4:0] count_after;
} list_result_t;

class list_shadow;
  localparam int Cap = 16;

  logic [31:0]  entries [Cap];
  int           count;
  int           errors;
  list_result_t pending_results [$];

  function new();
    count  = 0;
    errors = 0;
    foreach (entries[k]) entries[k] = '0;
  endfunction

  // Apply one accepted request to the shadow list and queue its result.
  function void note_request(logic [1:0] cmd, logic [31:0] val, logic [4:0] pos);
    list_result_t res;
    int           w;
    res.ok = 1'b0;
    case (cmd)
      plap_pkg::CmdInsert: begin
        if (int'(pos) <= count && count < Cap) begin
          for (int k = count; k > int'(pos); k--) entries[k] = entries[k-1];
          entries[pos] = val;
          count++;
          res.ok = 1'b1;
        end
      end
      plap_pkg::CmdDeleteAt: begin
        if (int'(pos) < count) begin
          for (int k = pos; k + 1 < count; k++) entries[k] = entries[k+1];
          count--;
          res.ok = 1'b1;
        end
      end
      plap_pkg::CmdDeleteVal: begin
        w = 0;
        for (int r = 0; r < count; r++) begin
          if (entries[r] != val) begin
            entries[w] = entries[r];
            w++;
          end
        end
        count  = w;
        res.ok = 1'b1;
      end
      default: res.ok = 1'b0;
    endcase
    res.count_after = count[4:0];
    pending_results.push_back(res);
  endfunction

  function void check_result(logic [7:0] data);
    list_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: ok %0d count_after %0d", data[0], data[5:1]);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (data[0] !== want.ok) begin
      $error("ok: expected %0d, actual %0d", want.ok, data[0]);
      errors++;
    end
    if (data[5:1] !== want.count_after) begin
      $error("count_after: expected %0d, actual %0d", want.count_after, data[5:1]);
      errors++;
    end
  endfunction

  function int pending();
    return pending_results.size();
  endfunction
endclass

module positional_list_insert_delete_top_test;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int IdleLimit  = 400;
  localparam int TailCycles = 30;
  localparam int RandomItems = 600;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [plap_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [plap_pkg::OutDataW-1:0] m_axis_tdata;

  list_shadow  sb = new();
  bit          steady = 1'b0;   // when set, neither side idles
  int          idle_cycles = 0;
  logic [31:0] pool [4] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0000};

  positional_list_insert_delete_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 4));
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] val,
                              input logic [4:0] pos);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {1'b0, pos, val, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, val, pos);
  endtask

  task automatic send_random_request();
    int          r;
    int          p_ins;
    logic [1:0]  cmd;
    logic [31:0] val;
    logic [4:0]  pos;
    p_ins = (sb.count < 4) ? 60 : (sb.count > 13) ? 30 : 45;
    r = $urandom_range(0, 99);
    if (r < p_ins) cmd = plap_pkg::CmdInsert;
    else if (r < p_ins + 28) cmd = plap_pkg::CmdDeleteAt;
    else if (r < 95) cmd = plap_pkg::CmdDeleteVal;
    else cmd = CmdUnused;

    val = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 3)] : $urandom;
    // delete-value mostly targets something actually in the list
    if (cmd == plap_pkg::CmdDeleteVal && sb.count > 0 && $urandom_range(0, 4) != 0)
      val = sb.entries[$urandom_range(0, sb.count - 1)];

    pos = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 85) begin
      if (cmd == plap_pkg::CmdInsert) pos = 5'($urandom_range(0, sb.count));
      else if (sb.count > 0) pos = 5'($urandom_range(0, sb.count - 1));
    end
    send_request(cmd, val, pos);
  endtask

  // Result side: random back-pressure, check every accepted result.
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("positional_list_insert_delete_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] val;
    logic [4:0]  pos;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty list: failing delete, harmless delete-value, unused code, insert past end
    send_request(plap_pkg::CmdDeleteAt, 32'h0, 5'd0);
    send_request(plap_pkg::CmdDeleteVal, 32'hffff_ffff, 5'd31);
    send_request(CmdUnused, 32'hffff_ffff, 5'd31);
    send_request(plap_pkg::CmdInsert, 32'h1234_5678, 5'd31);

    // fill to capacity at front, end and middle, with repeats of one value
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0:       val = 32'd5;
        1:       val = 32'h7fff_ffff;
        2:       val = 32'h8000_0000;
        default: val = $urandom;
      endcase
      case (i % 3)
        0:       pos = 5'd0;
        1:       pos = sb.count[4:0];
        default: pos = 5'(sb.count / 2);
      endcase
      send_request(plap_pkg::CmdInsert, val, pos);
    end
    send_request(plap_pkg::CmdInsert, 32'h0, 5'd16);      // full
    send_request(plap_pkg::CmdDeleteAt, 32'h0, 5'd16);    // position == count
    send_request(plap_pkg::CmdDeleteAt, 32'h0, 5'd15);    // last entry
    send_request(plap_pkg::CmdDeleteAt, 32'h0, 5'd0);     // first entry
    send_request(plap_pkg::CmdDeleteVal, 32'd5, 5'd0);    // several matches
    send_request(plap_pkg::CmdDeleteVal, 32'hdead_beef, 5'd0);  // no match

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      send_random_request();
    end
    steady = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("positional_list_insert_delete_top: match");
    end else begin
      $display("positional_list_insert_delete_top: mismatch");
    end
    $finish;
  end
endmodule
